>>> rtl/core/i2c_master_byte_engine_defines.svh
// assertion macros used by the engine's sequencer module
// each one expects signals named clk and arst_n in the module that uses it
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// same-cycle implication
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int unsigned BYTE_BITS   = 8;
	localparam int unsigned CFG_WIDTH   = 16;
	localparam logic [15:0] DELAY_RESET = 16'd160;

	// command codes on the input word
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// queue between front and sequencer
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = 2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_READ
	} op_t;

	// one classified tick
	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       with_start;
		logic       with_stop;
		logic       ack_to_send;
		logic       sda_in;
	} tick_t;

	// front to queue
	typedef struct packed {
		logic  valid;
		tick_t tick;
	} queue_in_t;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_LOW,
		PH_START_SCL,
		PH_START_BIT,
		PH_WBIT_HIGH,
		PH_WBIT_END,
		PH_RBIT_HIGH,
		PH_RBIT_END,
		PH_STOP_SCL,
		PH_STOP_SDA,
		PH_STOP_END
	} phase_t;

endpackage

>>> rtl/core/i2cm_if.sv
`timescale 1ns / 1ps

// tick word channel
interface i2cm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	logic       with_start;
	logic       with_stop;
	logic       ack_to_send;
	logic       sda_in;

	modport source (output valid, cmd, data_byte, with_start, with_stop, ack_to_send, sda_in,
		input ready);
	modport sink (input valid, cmd, data_byte, with_start, with_stop, ack_to_send, sda_in,
		output ready);
endinterface

// result word channel
interface i2cm_result_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_drive_enable;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic       ack_received;
	logic [7:0] read_byte;

	modport source (output valid, scl_level, sda_drive_enable, sda_level, busy_res, done_res,
		ack_received, read_byte, input ready);
	modport sink (input valid, scl_level, sda_drive_enable, sda_level, busy_res, done_res,
		ack_received, read_byte, output ready);
endinterface

// delay register write channel
interface i2cm_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front (
	input  logic                clk,
	input  logic                arst_n,
	i2cm_item_if.sink           item,
	output i2cm_pkg::queue_in_t push,
	input  logic                queue_full
);

	logic            valid_s1;
	i2cm_pkg::tick_t tick_s1;
	i2cm_pkg::tick_t tick_dec;

	// take a word whenever the stage is empty or drains this cycle
	assign item.ready = !valid_s1 || !queue_full;

	// classify the command, unused code is a plain tick
	always_comb begin
		tick_dec.data_byte   = item.data_byte;
		tick_dec.with_start  = item.with_start;
		tick_dec.with_stop   = item.with_stop;
		tick_dec.ack_to_send = item.ack_to_send;
		tick_dec.sda_in      = item.sda_in;
		unique case (item.cmd)
			i2cm_pkg::CMD_WRITE: tick_dec.op = i2cm_pkg::OP_WRITE;
			i2cm_pkg::CMD_READ:  tick_dec.op = i2cm_pkg::OP_READ;
			default:             tick_dec.op = i2cm_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			tick_s1 <= tick_dec;
		end
	end

	assign push.valid = valid_s1;
	assign push.tick  = tick_s1;

endmodule

>>> rtl/core/i2cm_queue.sv
`timescale 1ns / 1ps

module i2cm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  i2cm_pkg::queue_in_t push,
	output logic                full,
	output logic                out_valid,
	output i2cm_pkg::tick_t     out_tick,
	input  logic                pop
);

	localparam int unsigned AW = i2cm_pkg::QUEUE_AW;

	i2cm_pkg::tick_t mem_q [i2cm_pkg::QUEUE_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = count_q == (AW + 1)'(i2cm_pkg::QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_tick  = mem_q[rd_ptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = out_valid && pop;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.tick;
		end
	end

endmodule

>>> rtl/core/i2cm_seq.sv
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_defines.svh"

module i2cm_seq #(
	parameter int unsigned DELAY_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [i2cm_pkg::CFG_WIDTH-1:0]     delay_ticks,
	input  logic                               q_valid,
	input  i2cm_pkg::tick_t                    q_tick,
	output logic                               q_pop,
	i2cm_result_if.source                      result
);

	i2cm_pkg::phase_t       phase_q, phase_d;
	logic [DELAY_WIDTH-1:0] delay_cnt_q, delay_cnt_d;
	logic [DELAY_WIDTH-1:0] reload;
	logic [7:0]             shift_q, shift_d;
	logic [3:0]             bit_cnt_q, bit_cnt_d;
	logic [3:0]             bit_inc;
	logic                   more_bits;
	logic                   is_read_q, is_read_d;
	logic                   stop_q, stop_d;
	logic                   ack_latch_q, ack_latch_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	logic                   sda_en_q, sda_en_d;
	logic                   last_ack_q, last_ack_d;
	logic [7:0]             hold_q, hold_d;
	logic                   done_q, done_d;
	logic                   res_valid_q;
	logic                   step;
	logic                   idle;
	logic                   expired;
	logic                   load;

	// one tick is retired whenever the result slot is free or taken
	assign step      = q_valid && (!res_valid_q || result.ready);
	assign q_pop     = step;
	assign idle      = phase_q == i2cm_pkg::PH_IDLE;
	assign expired   = delay_cnt_q <= DELAY_WIDTH'(1);
	assign bit_inc   = bit_cnt_q + 4'd1;
	assign more_bits = bit_inc < 4'(i2cm_pkg::BYTE_BITS);

	// half-period reload, zero acts as one
	always_comb begin
		reload = DELAY_WIDTH'(delay_ticks);
		if (reload == '0) begin
			reload = DELAY_WIDTH'(1);
		end
	end

	// next phase and delay counter
	always_comb begin
		phase_d     = phase_q;
		delay_cnt_d = delay_cnt_q;
		load        = 1'b0;
		if (idle) begin
			unique case (q_tick.op)
				i2cm_pkg::OP_WRITE: begin
					phase_d = q_tick.with_start ? i2cm_pkg::PH_START_LOW
						: i2cm_pkg::PH_WBIT_HIGH;
					load = 1'b1;
				end
				i2cm_pkg::OP_READ: begin
					phase_d = i2cm_pkg::PH_RBIT_HIGH;
					load    = 1'b1;
				end
				default: ;
			endcase
		end else if (!expired) begin
			delay_cnt_d = delay_cnt_q - 1'b1;
		end else begin
			delay_cnt_d = '0;
			load        = 1'b1;
			unique case (phase_q)
				i2cm_pkg::PH_START_LOW: phase_d = i2cm_pkg::PH_START_SCL;
				i2cm_pkg::PH_START_SCL: phase_d = i2cm_pkg::PH_START_BIT;
				i2cm_pkg::PH_START_BIT: phase_d = i2cm_pkg::PH_WBIT_HIGH;
				i2cm_pkg::PH_WBIT_HIGH: phase_d = i2cm_pkg::PH_WBIT_END;
				i2cm_pkg::PH_WBIT_END: begin
					if (is_read_q) begin
						phase_d = stop_q ? i2cm_pkg::PH_STOP_SCL : i2cm_pkg::PH_IDLE;
						load    = stop_q;
					end else begin
						phase_d = more_bits ? i2cm_pkg::PH_WBIT_HIGH
							: i2cm_pkg::PH_RBIT_HIGH;
					end
				end
				i2cm_pkg::PH_RBIT_HIGH: phase_d = i2cm_pkg::PH_RBIT_END;
				i2cm_pkg::PH_RBIT_END: begin
					if (!is_read_q) begin
						phase_d = stop_q ? i2cm_pkg::PH_STOP_SCL : i2cm_pkg::PH_IDLE;
						load    = stop_q;
					end else begin
						phase_d = more_bits ? i2cm_pkg::PH_RBIT_HIGH
							: i2cm_pkg::PH_WBIT_HIGH;
					end
				end
				i2cm_pkg::PH_STOP_SCL: phase_d = i2cm_pkg::PH_STOP_SDA;
				i2cm_pkg::PH_STOP_SDA: phase_d = i2cm_pkg::PH_STOP_END;
				default: begin
					phase_d = i2cm_pkg::PH_IDLE;
					load    = 1'b0;
				end
			endcase
		end
		if (load) begin
			delay_cnt_d = reload;
		end
	end

	// line drive, shifter and status
	always_comb begin
		shift_d     = shift_q;
		bit_cnt_d   = bit_cnt_q;
		is_read_d   = is_read_q;
		stop_d      = stop_q;
		ack_latch_d = ack_latch_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		sda_en_d    = sda_en_q;
		last_ack_d  = last_ack_q;
		hold_d      = hold_q;
		done_d      = 1'b0;
		if (idle) begin
			unique case (q_tick.op)
				i2cm_pkg::OP_WRITE: begin
					is_read_d = 1'b0;
					stop_d    = q_tick.with_stop;
					shift_d   = q_tick.data_byte;
					bit_cnt_d = '0;
					sda_en_d  = 1'b1;
					if (q_tick.with_start) begin
						sda_d = 1'b1;
						scl_d = 1'b1;
					end else begin
						sda_d = q_tick.data_byte[7];
					end
				end
				i2cm_pkg::OP_READ: begin
					is_read_d   = 1'b1;
					stop_d      = q_tick.with_stop;
					ack_latch_d = q_tick.ack_to_send;
					shift_d     = '0;
					bit_cnt_d   = '0;
					sda_en_d    = 1'b0;
				end
				default: ;
			endcase
		end else if (expired) begin
			unique case (phase_q)
				i2cm_pkg::PH_START_LOW: sda_d = 1'b0;
				i2cm_pkg::PH_START_SCL: begin
					scl_d = 1'b0;
					sda_d = shift_q[7];
				end
				i2cm_pkg::PH_START_BIT: sda_d = shift_q[7];
				i2cm_pkg::PH_WBIT_HIGH: scl_d = 1'b1;
				i2cm_pkg::PH_WBIT_END: begin
					scl_d = 1'b0;
					if (is_read_q) begin
						// ack slot of a read done: stop setup or finish
						if (stop_q) begin
							sda_en_d = 1'b1;
							sda_d    = 1'b0;
						end else begin
							done_d = 1'b1;
						end
					end else begin
						shift_d   = {shift_q[6:0], 1'b0};
						bit_cnt_d = bit_inc;
						if (more_bits) begin
							sda_d = shift_q[6];
						end else begin
							sda_en_d = 1'b0;
						end
					end
				end
				i2cm_pkg::PH_RBIT_HIGH: scl_d = 1'b1;
				i2cm_pkg::PH_RBIT_END: begin
					scl_d    = 1'b0;
					sda_en_d = 1'b1;
					if (!is_read_q) begin
						// ack slot of a write
						last_ack_d = q_tick.sda_in;
						if (stop_q) begin
							sda_d = 1'b0;
						end else begin
							done_d = 1'b1;
						end
					end else begin
						shift_d   = {shift_q[6:0], q_tick.sda_in};
						bit_cnt_d = bit_inc;
						if (more_bits) begin
							sda_en_d = 1'b0;
						end else begin
							hold_d = {shift_q[6:0], q_tick.sda_in};
							sda_d  = ack_latch_q;
						end
					end
				end
				i2cm_pkg::PH_STOP_SCL: scl_d = 1'b1;
				i2cm_pkg::PH_STOP_SDA: sda_d = 1'b1;
				default: done_d = 1'b1;
			endcase
		end
	end

	// state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= i2cm_pkg::PH_IDLE;
			delay_cnt_q <= '0;
			shift_q     <= '0;
			bit_cnt_q   <= '0;
			is_read_q   <= 1'b0;
			stop_q      <= 1'b0;
			ack_latch_q <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			sda_en_q    <= 1'b1;
			last_ack_q  <= 1'b0;
			hold_q      <= '0;
			done_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_d;
				delay_cnt_q <= delay_cnt_d;
				shift_q     <= shift_d;
				bit_cnt_q   <= bit_cnt_d;
				is_read_q   <= is_read_d;
				stop_q      <= stop_d;
				ack_latch_q <= ack_latch_d;
				scl_q       <= scl_d;
				sda_q       <= sda_d;
				sda_en_q    <= sda_en_d;
				last_ack_q  <= last_ack_d;
				hold_q      <= hold_d;
				done_q      <= done_d;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid            = res_valid_q;
	assign result.scl_level        = scl_q;
	assign result.sda_drive_enable = sda_en_q;
	assign result.sda_level        = sda_q;
	assign result.busy_res         = !idle;
	assign result.done_res         = done_q;
	assign result.ack_received     = last_ack_q;
	assign result.read_byte        = hold_q;

	// checks
	`I2CM_ASSERT_NOW(a_done_idle, done_q, phase_q == i2cm_pkg::PH_IDLE, "done while busy")
	`I2CM_ASSERT_NOW(a_cnt_loaded, phase_q != i2cm_pkg::PH_IDLE, delay_cnt_q != '0, "busy with empty delay")
	`I2CM_ASSERT_NOW(a_release, !sda_en_q, phase_q == i2cm_pkg::PH_RBIT_HIGH || phase_q == i2cm_pkg::PH_RBIT_END, "sda released outside read slot")
	`I2CM_ASSERT_NOW(a_bit_range, 1'b1, bit_cnt_q <= 4'(i2cm_pkg::BYTE_BITS), "bit counter overrun")
	`I2CM_ASSERT_NEXT(a_stall_hold, res_valid_q && !result.ready, $stable(phase_q) && $stable(delay_cnt_q), "sequencer moved under stall")

endmodule

>>> rtl/core/i2c_master_byte_engine.sv
`timescale 1ns / 1ps

// I2C master byte engine. Every word on the item channel is one bus tick:
// it carries an optional command (write byte, read byte) and the sampled
// SDA level. While the engine is idle a write or read command starts a
// byte transfer; commands that arrive while busy are dropped.
// Every item produces exactly one word on the result channel with the pin
// drive (scl, sda, sda enable), busy, a done pulse, the last ack sampled
// and the last byte read. The cfg channel writes the half-period delay in
// ticks; it is always ready. The user must write it only while no word is
// in flight; the block does not enforce this. A result passes the input
// register, queue and sequencer. Throughput is one item per cycle, set by
// the sequencer retiring one tick per cycle while results are not stalled.
// Reset: SCL and SDA high with SDA driven, delay 160 ticks, engine idle.
// Result stall: the sequencer holds, the four-entry queue and the input
// register keep taking items, then item.ready drops until words drain.
module i2c_master_byte_engine #(
	parameter int unsigned DELAY_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	i2cm_item_if.sink     item,
	i2cm_cfg_if.sink      cfg,
	i2cm_result_if.source result
);

	logic [i2cm_pkg::CFG_WIDTH-1:0] delay_q;
	i2cm_pkg::queue_in_t            push;
	logic                           queue_full;
	logic                           q_valid;
	i2cm_pkg::tick_t                q_tick;
	logic                           q_pop;

	// delay register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= i2cm_pkg::DELAY_RESET;
		end else if (cfg.valid) begin
			delay_q <= cfg.data;
		end
	end

	i2cm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push       (push),
		.queue_full (queue_full)
	);

	i2cm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (queue_full),
		.out_valid (q_valid),
		.out_tick  (q_tick),
		.pop       (q_pop)
	);

	i2cm_seq #(
		.DELAY_WIDTH (DELAY_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.delay_ticks (delay_q),
		.q_valid     (q_valid),
		.q_tick      (q_tick),
		.q_pop       (q_pop),
		.result      (result)
	);

endmodule
